// ----- hdl/rcm_pkg.sv -----
// shared types and constants for the rc drive mode multiplexer
package rcm_pkg;

  // one control pass as it arrives from the receiver front end
  typedef struct packed {
    logic [31:0]        time_ms;
    logic [14:0]        override_pulse_us;
    logic [14:0]        blink_select_pulse_us;
    logic [14:0]        mode_pulse_us;
    logic [14:0]        steer_pulse_in_us;
    logic [14:0]        throttle_pulse_in_us;
    logic               cmd_valid;
    logic signed [15:0] steer_cmd;
    logic signed [15:0] throttle_cmd;
  } rcm_in_t;

  // indicator levels and servo/esc updates for one pass
  typedef struct packed {
    logic        auto_led;
    logic        high_blink_led;
    logic        low_blink_led;
    logic        steer_write;
    logic [10:0] steer_pulse_out_us;
    logic        throttle_write;
    logic [10:0] throttle_pulse_out_us;
  } rcm_out_t;

  // thresholds on measured receiver pulses
  localparam logic [14:0] SWITCH_TH_US    = 15'd1500;
  localparam logic [14:0] BLINK_HIGH_TH   = 15'd1900;
  localparam logic [14:0] BLINK_LOW_TH    = 15'd1100;
  localparam logic [14:0] PULSE_MIN_US    = 15'd1000;
  localparam logic [14:0] PULSE_MAX_US    = 15'd2000;

  // output pulse constants
  localparam logic [10:0] NEUTRAL_US      = 11'd1500;
  localparam logic [10:0] DEADBAND_US     = 11'd1553;
  localparam logic [10:0] FWD_BASE_US     = 11'd1520;
  localparam logic [10:0] REV_BASE_US     = 11'd1100;
  localparam logic [10:0] STEER_BASE_US   = 11'd1000;
  localparam logic [10:0] MAN_CENTER_US   = 11'd1504;

  // command mapping spans
  localparam int unsigned FWD_SPAN_US     = 100;
  localparam int unsigned REV_SPAN_US     = 380;
  localparam logic signed [15:0] STEER_CMD_LIM = 16'sd100;

  localparam logic [15:0] TOGGLE_PERIOD_RST = 16'd300;

endpackage

// ----- hdl/rcm_in_if.sv -----
// valid/ready channel carrying one control pass
interface rcm_in_if import rcm_pkg::*; ();
  logic    valid;
  logic    ready;
  rcm_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/rcm_out_if.sv -----
// valid/ready channel carrying one pass result
interface rcm_out_if import rcm_pkg::*; ();
  logic     valid;
  logic     ready;
  rcm_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/rc_drive_mode_mux.sv -----
// rc drive mode multiplexer: mode select, command mapping and indicator blink
//
// item channel: one control pass per transfer (time, receiver pulses, host command)
// result channel: one result per pass (mode/blink leds, steering and throttle updates)
// cfg_wr_en/cfg_wr_data: writes the led toggle period in ms; only while no pass is in flight
//
// two register stages: an input register, then short logic into the result register;
// a pass taken into the input register moves into the result register as soon as that
// register is free, which raises result valid
// a new pass is taken every cycle unless both registers are full; the throttle mapping
// uses one reciprocal multiply per direction, the longest path between the two stages
// the blink state (led levels and timestamps) is updated as a pass moves into the
// result register, so passes see state strictly in transfer order
// when the receiver stalls, the result register holds and the input register still
// fills, so at most two passes wait; item.ready falls only when both are full
// reset clears both valid flags, both leds and timestamps, and sets the toggle
// period to 300 ms
module rc_drive_mode_mux import rcm_pkg::*; #(
  parameter int unsigned FORWARD_MAX = 40,
  parameter int unsigned REVERSE_MAX = 75
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  rcm_in_if.sink      item,
  rcm_out_if.source   result
);

  // reciprocals for the constant divisions t*100/FORWARD_MAX and u*380/REVERSE_MAX;
  // with 16 fraction bits the rounding error stays below one lsb for t, u <= 100
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [31:0] FWD_RECIP =
    32'((FWD_SPAN_US * (1 << RECIP_SHIFT) + FORWARD_MAX - 1) / FORWARD_MAX);
  localparam logic [31:0] REV_RECIP =
    32'((REV_SPAN_US * (1 << RECIP_SHIFT) + REVERSE_MAX - 1) / REVERSE_MAX);

  localparam logic signed [15:0] FWD_LIM_S = 16'(FORWARD_MAX);
  localparam logic signed [15:0] REV_LIM_S = 16'(REVERSE_MAX);
  localparam logic signed [15:0] REV_NEG_S = 16'(-int'(REVERSE_MAX));

  // manual throttle clamp points on the input pulse and the matching outputs
  localparam logic [14:0] MAN_HI_US  = 15'(int'(NEUTRAL_US) + int'(FORWARD_MAX));
  localparam logic [14:0] MAN_LO_US  = 15'(int'(NEUTRAL_US) - int'(REVERSE_MAX));
  localparam logic [10:0] MAN_THR_HI = 11'(int'(MAN_CENTER_US) + int'(FORWARD_MAX));
  localparam logic [10:0] MAN_THR_LO = 11'(int'(MAN_CENTER_US) - int'(REVERSE_MAX));
  localparam logic [10:0] MAN_SHIFT  = MAN_CENTER_US - NEUTRAL_US;

  // configuration
  logic [15:0] toggle_period;

  // blink state
  logic        high_blink_on, high_blink_on_next;
  logic        low_blink_on, low_blink_on_next;
  logic [31:0] high_blink_stamp, high_blink_stamp_next;
  logic [31:0] low_blink_stamp, low_blink_stamp_next;

  // pipeline registers
  rcm_in_t  in_q;
  logic     in_vld;
  rcm_out_t res_q, res_next;
  logic     res_vld;

  logic res_free;
  logic adv;

  // handshake: result register frees when empty or being taken
  assign res_free   = !res_vld || result.ready;
  assign adv        = in_vld && res_free;
  assign item.ready = !in_vld || res_free;

  assign result.valid   = res_vld;
  assign result.payload = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_period <= TOGGLE_PERIOD_RST;
    end else if (cfg_wr_en) begin
      toggle_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (item.ready) begin
      in_vld <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_q <= item.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (res_free) begin
      res_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_blink_on    <= 1'b0;
      low_blink_on     <= 1'b0;
      high_blink_stamp <= '0;
      low_blink_stamp  <= '0;
    end else if (adv) begin
      high_blink_on    <= high_blink_on_next;
      low_blink_on     <= low_blink_on_next;
      high_blink_stamp <= high_blink_stamp_next;
      low_blink_stamp  <= low_blink_stamp_next;
    end
  end

  // ---------------------------------------------------------------- blink leds
  logic        ovr_on;
  logic        high_sel, low_sel;
  logic        high_due, low_due;
  logic [31:0] interval_ext;

  assign ovr_on       = in_q.override_pulse_us > SWITCH_TH_US;
  assign high_sel     = in_q.blink_select_pulse_us >= BLINK_HIGH_TH;
  assign low_sel      = (in_q.blink_select_pulse_us != '0) &&
                        (in_q.blink_select_pulse_us <= BLINK_LOW_TH);
  assign interval_ext = {16'd0, toggle_period};
  // elapsed time is taken modulo 2^32 so a wrapped clock still counts right
  assign high_due     = (in_q.time_ms - high_blink_stamp) >= interval_ext;
  assign low_due      = (in_q.time_ms - low_blink_stamp) >= interval_ext;

  always_comb begin
    high_blink_on_next    = high_blink_on;
    low_blink_on_next     = low_blink_on;
    high_blink_stamp_next = high_blink_stamp;
    low_blink_stamp_next  = low_blink_stamp;
    if (ovr_on) begin
      // override lights both, timers keep running from their old stamps
      high_blink_on_next = 1'b1;
      low_blink_on_next  = 1'b1;
    end else begin
      if (!high_sel) begin
        high_blink_on_next    = 1'b0;
        high_blink_stamp_next = in_q.time_ms;
      end else if (high_due) begin
        high_blink_on_next    = !high_blink_on;
        high_blink_stamp_next = in_q.time_ms;
      end
      if (!low_sel) begin
        low_blink_on_next    = 1'b0;
        low_blink_stamp_next = in_q.time_ms;
      end else if (low_due) begin
        low_blink_on_next    = !low_blink_on;
        low_blink_stamp_next = in_q.time_ms;
      end
    end
  end

  // ------------------------------------------------------- auto steering map
  logic [7:0]  steer_idx;
  logic [15:0] steer_sum;
  logic [10:0] steer_auto;

  assign steer_sum = in_q.steer_cmd + STEER_CMD_LIM;

  always_comb begin
    priority if (in_q.steer_cmd < -STEER_CMD_LIM) begin
      steer_idx = 8'd0;
    end else if (in_q.steer_cmd > STEER_CMD_LIM) begin
      steer_idx = 8'd200;
    end else begin
      steer_idx = steer_sum[7:0];
    end
  end

  // (s+100)*1000/200 is exactly (s+100)*5
  assign steer_auto = STEER_BASE_US + {1'b0, steer_idx, 2'b00} + {3'd0, steer_idx};

  // ------------------------------------------------------- auto throttle map
  logic [6:0]  fwd_t, rev_u;
  logic [15:0] rev_sum;
  logic [31:0] fwd_prod, rev_prod;
  logic [10:0] thr_map, thr_auto;

  assign rev_sum = in_q.throttle_cmd + REV_LIM_S;

  always_comb begin
    if (in_q.throttle_cmd > FWD_LIM_S) begin
      fwd_t = FWD_LIM_S[6:0];
    end else begin
      fwd_t = in_q.throttle_cmd[6:0];
    end
    if (in_q.throttle_cmd <= REV_NEG_S) begin
      rev_u = 7'd0;
    end else begin
      rev_u = rev_sum[6:0];
    end
  end

  assign fwd_prod = {25'd0, fwd_t} * FWD_RECIP;
  assign rev_prod = {25'd0, rev_u} * REV_RECIP;

  always_comb begin
    if (!in_q.throttle_cmd[15]) begin
      thr_map = FWD_BASE_US + {4'd0, fwd_prod[RECIP_SHIFT +: 7]};
    end else begin
      thr_map = REV_BASE_US + {2'd0, rev_prod[RECIP_SHIFT +: 9]};
    end
    // lift anything just above neutral to the esc deadband floor
    if (thr_map > NEUTRAL_US && thr_map < DEADBAND_US) begin
      thr_auto = DEADBAND_US;
    end else begin
      thr_auto = thr_map;
    end
  end

  // ------------------------------------------------------ manual pass-through
  logic        steer_in_ok, thr_in_ok;
  logic [10:0] thr_manual;

  assign steer_in_ok = (in_q.steer_pulse_in_us >= PULSE_MIN_US) &&
                       (in_q.steer_pulse_in_us <= PULSE_MAX_US);
  assign thr_in_ok   = (in_q.throttle_pulse_in_us >= PULSE_MIN_US) &&
                       (in_q.throttle_pulse_in_us <= PULSE_MAX_US);

  always_comb begin
    priority if (in_q.throttle_pulse_in_us > MAN_HI_US) begin
      thr_manual = MAN_THR_HI;
    end else if (in_q.throttle_pulse_in_us < MAN_LO_US) begin
      thr_manual = MAN_THR_LO;
    end else begin
      thr_manual = in_q.throttle_pulse_in_us[10:0] + MAN_SHIFT;
    end
  end

  // ------------------------------------------------------------ result word
  logic auto_mode;
  assign auto_mode = in_q.mode_pulse_us > SWITCH_TH_US;

  always_comb begin
    res_next.auto_led              = auto_mode;
    res_next.high_blink_led        = high_blink_on_next;
    res_next.low_blink_led         = low_blink_on_next;
    res_next.steer_write           = 1'b0;
    res_next.steer_pulse_out_us    = NEUTRAL_US;
    res_next.throttle_write        = 1'b0;
    res_next.throttle_pulse_out_us = NEUTRAL_US;
    if (auto_mode) begin
      res_next.steer_write    = 1'b1;
      res_next.throttle_write = 1'b1;
      if (in_q.cmd_valid) begin
        res_next.steer_pulse_out_us    = steer_auto;
        res_next.throttle_pulse_out_us = thr_auto;
      end
    end else begin
      if (steer_in_ok) begin
        res_next.steer_write        = 1'b1;
        res_next.steer_pulse_out_us = in_q.steer_pulse_in_us[10:0];
      end
      if (thr_in_ok) begin
        res_next.throttle_write        = 1'b1;
        res_next.throttle_pulse_out_us = thr_manual;
      end
    end
  end

  // ------------------------------------------------------------- assertions
  // override forces both leds on in the result of that same pass
  a_override_leds: assert property (@(posedge clk) disable iff (rst)
    adv && ovr_on |=> result.payload.high_blink_led && result.payload.low_blink_led)
    else $error("override pass did not light both leds");

  // auto mode always updates both outputs
  a_auto_writes: assert property (@(posedge clk) disable iff (rst)
    adv && auto_mode |=> result.payload.steer_write && result.payload.throttle_write)
    else $error("auto pass missing a write flag");

  // steering stays within the servo range
  a_steer_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.payload.steer_pulse_out_us >= STEER_BASE_US &&
                     result.payload.steer_pulse_out_us <= PULSE_MAX_US[10:0])
    else $error("steering pulse out of range");

  // auto-mode throttle is never inside the deadband gap
  a_thr_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.auto_led |->
      result.payload.throttle_pulse_out_us <= NEUTRAL_US ||
      result.payload.throttle_pulse_out_us >= DEADBAND_US)
    else $error("auto throttle pulse inside deadband");

endmodule
